/* sv/axf_pkg.sv */
// ----------------------------------------------------------------------------
// axf_pkg: shared types and constants of the 8086-style ALU flags unit
// Holds the opcode and state codes, the flag bit positions and the
// command and status structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package axf_pkg;

    localparam int DATA_W    = 16;
    localparam int FLAGS_W   = 8;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Flag bit positions.
    localparam int F_CARRY  = 0;
    localparam int F_PARITY = 1;
    localparam int F_ADJUST = 2;
    localparam int F_ZERO   = 3;
    localparam int F_SIGN   = 4;
    localparam int F_OVFL   = 5;
    localparam int F_INTR   = 6;
    localparam int F_DIR    = 7;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_CMP  = 4'd1,
        OP_INC  = 4'd2,
        OP_DEC  = 4'd3,
        OP_XOR  = 4'd4,
        OP_DIV  = 4'd5,
        OP_COND = 4'd6,
        OP_STC  = 4'd7,
        OP_CLD  = 4'd8,
        OP_STD  = 4'd9,
        OP_CLI  = 4'd10,
        OP_STI  = 4'd11
    } op_t;

    // Condition groups, selected by bits [3:1] of the Jcc code.
    typedef enum logic [2:0] {
        CG_O   = 3'd0,
        CG_B   = 3'd1,
        CG_Z   = 3'd2,
        CG_BE  = 3'd3,
        CG_S   = 3'd4,
        CG_P   = 3'd5,
        CG_L   = 3'd6,
        CG_LE  = 3'd7
    } cond_grp_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_DIV  = 2'd2,
        ST_FIN  = 2'd3
    } state_t;

    typedef struct packed {
        logic load;       // capture the operands of an accepted beat
        logic div_start;  // seed the divider
        logic div_step;   // one quotient bit
        logic commit;     // update flags and output registers
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_run;    // divide with a nonzero divisor is pending
    } dp_sts_t;

endpackage

/* sv/axf_ctrl.sv */
// ----------------------------------------------------------------------------
// axf_ctrl: sequencing controller of the ALU flags unit
// Steps each beat through operand capture, execution or the divide loop,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module axf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output axf_pkg::ctrl_cmd_t cmd,
    input  axf_pkg::dp_sts_t  sts
);
    import axf_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.div_run)
                begin
                    cmd.div_start = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
                else if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // A result is never overwritten while the sink still holds it off.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("commit while output is stalled");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_load_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_start, cmd.div_step, cmd.commit}))
        else $error("overlapping datapath commands");

endmodule

/* sv/axf_dp.sv */
// ----------------------------------------------------------------------------
// axf_dp: datapath of the ALU flags unit
// Operand registers, adder/subtractor with flag logic, a restoring divider
// that yields one quotient bit per cycle, the flags register and the
// output registers.
// ----------------------------------------------------------------------------
module axf_dp
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  axf_pkg::ctrl_cmd_t         cmd,
    output axf_pkg::dp_sts_t           sts,
    input  logic [3:0]                 opcode,
    input  logic                       word_size,
    input  logic [axf_pkg::DATA_W-1:0] left_operand,
    input  logic [axf_pkg::DATA_W-1:0] right_operand,
    input  logic [3:0]                 condition_code,
    output logic [axf_pkg::DATA_W-1:0] result_value,
    output logic                       write_back,
    output logic                       branch_taken,
    output logic                       divide_fault,
    output logic [axf_pkg::FLAGS_W-1:0] flags_value
);
    import axf_pkg::*;

    op_t                op_reg;
    logic               wsz_reg;
    logic [DATA_W-1:0]  l_reg;
    logic [DATA_W-1:0]  r_reg;
    logic [3:0]         cc_reg;
    logic [DATA_W-1:0]  rem_reg;
    logic [DATA_W-1:0]  quo_reg;
    logic [FLAGS_W-1:0] flags_reg;
    logic [FLAGS_W-1:0] flags_next;
    logic [DATA_W-1:0]  res_reg;
    logic [DATA_W-1:0]  res_next;
    logic               wb_reg;
    logic               wb_next;
    logic               taken_reg;
    logic               taken_next;
    logic               fault_reg;
    logic               fault_next;

    logic [DATA_W-1:0]  byte_mask;
    logic [DATA_W-1:0]  b_opnd;
    logic               is_sub;
    logic [DATA_W:0]    wide;
    logic [DATA_W-1:0]  ar_res;
    logic [DATA_W-1:0]  x_res;
    logic               ar_c;
    logic               ar_o;
    logic               ar_a;
    logic               r_zero;
    logic [DATA_W:0]    trial;
    logic               q_bit;
    logic [FLAGS_W-1:0] ar_flags;
    logic [FLAGS_W-1:0] x_flags;
    logic               cond_base;

    function automatic logic sign_of(input logic [DATA_W-1:0] v, input logic wsz);
        sign_of = wsz ? v[DATA_W-1] : v[7];
    endfunction

    // Sign, zero and parity bits placed at their flag positions.
    function automatic logic [FLAGS_W-1:0] szp(input logic [DATA_W-1:0] v,
                                               input logic wsz);
        logic [FLAGS_W-1:0] f;
        f           = '0;
        f[F_PARITY] = ~^v[7:0];
        f[F_ZERO]   = (v == '0);
        f[F_SIGN]   = sign_of(v, wsz);
        return f;
    endfunction

    assign byte_mask = word_size ? {DATA_W{1'b1}} : DATA_W'(8'hff);

    // Operand capture; for byte size the upper byte is dropped here.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(opcode);
            wsz_reg <= word_size;
            l_reg   <= left_operand & byte_mask;
            r_reg   <= right_operand & byte_mask;
            cc_reg  <= condition_code;
        end
    end

    // Adder/subtractor shared by add, cmp, inc and dec.
    assign is_sub = (op_reg == OP_CMP) || (op_reg == OP_DEC);
    assign b_opnd = ((op_reg == OP_INC) || (op_reg == OP_DEC)) ? DATA_W'(1) : r_reg;
    assign wide   = is_sub ? ({1'b0, l_reg} - {1'b0, b_opnd})
                           : ({1'b0, l_reg} + {1'b0, b_opnd});
    assign ar_res = wsz_reg ? wide[DATA_W-1:0] : {8'h00, wide[7:0]};
    assign ar_c   = (is_sub || wsz_reg) ? wide[DATA_W] : wide[8];
    assign ar_o   = is_sub ? sign_of((ar_res ^ l_reg) & (l_reg ^ b_opnd), wsz_reg)
                           : sign_of((ar_res ^ l_reg) & ~(l_reg ^ b_opnd), wsz_reg);
    assign ar_a   = l_reg[4] ^ b_opnd[4] ^ ar_res[4];
    assign x_res  = l_reg ^ r_reg;
    assign r_zero = (r_reg == '0);

    always_comb
    begin
        ar_flags         = szp(ar_res, wsz_reg);
        ar_flags[F_OVFL] = ar_o;
        ar_flags[F_ADJUST] = ar_a;
        ar_flags[F_INTR] = flags_reg[F_INTR];
        ar_flags[F_DIR]  = flags_reg[F_DIR];
        if ((op_reg == OP_INC) || (op_reg == OP_DEC))
        begin
            ar_flags[F_CARRY] = flags_reg[F_CARRY];
        end
        else
        begin
            ar_flags[F_CARRY] = ar_c;
        end

        x_flags           = szp(x_res, wsz_reg);
        x_flags[F_ADJUST] = flags_reg[F_ADJUST];
        x_flags[F_INTR]   = flags_reg[F_INTR];
        x_flags[F_DIR]    = flags_reg[F_DIR];
    end

    always_comb
    begin
        case (cond_grp_t'(cc_reg[3:1]))
            CG_O:    cond_base = flags_reg[F_OVFL];
            CG_B:    cond_base = flags_reg[F_CARRY];
            CG_Z:    cond_base = flags_reg[F_ZERO];
            CG_BE:   cond_base = flags_reg[F_CARRY] | flags_reg[F_ZERO];
            CG_S:    cond_base = flags_reg[F_SIGN];
            CG_P:    cond_base = flags_reg[F_PARITY];
            CG_L:    cond_base = flags_reg[F_SIGN] ^ flags_reg[F_OVFL];
            default: cond_base = (flags_reg[F_SIGN] ^ flags_reg[F_OVFL])
                                 | flags_reg[F_ZERO];
        endcase
    end

    // Restoring divider: one quotient bit per step, dividend shifted out of quo_reg.
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign q_bit = (trial >= {1'b0, r_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= l_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? DATA_W'(trial - {1'b0, r_reg}) : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], q_bit};
        end
    end

    assign sts.div_run = (op_reg == OP_DIV) && !r_zero;

    always_comb
    begin
        flags_next = flags_reg;
        res_next   = '0;
        wb_next    = 1'b0;
        taken_next = 1'b0;
        fault_next = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                flags_next = ar_flags;
                res_next   = ar_res;
                wb_next    = 1'b1;
            end
            OP_CMP:
            begin
                flags_next = ar_flags;
                res_next   = ar_res;
            end
            OP_INC, OP_DEC:
            begin
                flags_next = ar_flags;
                res_next   = ar_res;
                wb_next    = 1'b1;
            end
            OP_XOR:
            begin
                flags_next = x_flags;
                res_next   = x_res;
                wb_next    = 1'b1;
            end
            OP_DIV:
            begin
                if (r_zero)
                begin
                    fault_next = 1'b1;
                end
                else
                begin
                    res_next = quo_reg;
                    wb_next  = 1'b1;
                end
            end
            OP_COND: taken_next = cond_base ^ cc_reg[0];
            OP_STC:  flags_next[F_CARRY] = 1'b1;
            OP_CLD:  flags_next[F_DIR]   = 1'b0;
            OP_STD:  flags_next[F_DIR]   = 1'b1;
            OP_CLI:  flags_next[F_INTR]  = 1'b0;
            OP_STI:  flags_next[F_INTR]  = 1'b1;
            default: flags_next = flags_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (cmd.commit)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg   <= res_next;
            wb_reg    <= wb_next;
            taken_reg <= taken_next;
            fault_reg <= fault_next;
        end
    end

    // Flags change only on commit, together with the rest of the result.
    assign result_value = res_reg;
    assign write_back   = wb_reg;
    assign branch_taken = taken_reg;
    assign divide_fault = fault_reg;
    assign flags_value  = flags_reg;

endmodule

/* sv/x86_alu_flags_unit.sv */
// ----------------------------------------------------------------------------
// x86_alu_flags_unit: 8086-style ALU with a kept flags register
// Top level: joins the sequencing controller and the datapath.
// ----------------------------------------------------------------------------
// An accepted beat is captured, executed and committed to the output
// registers once they are free; a divide with a nonzero divisor is seeded
// and run through the one-bit-per-cycle restoring divider (16 steps) before
// its commit. The controller works on one beat at a time and takes no new
// beat until the last one has been committed.
// Reset: asynchronous active-low rst_n clears the flags and the control state.
// ----------------------------------------------------------------------------
module x86_alu_flags_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [3:0]                  opcode,
    input  logic                        word_size,
    input  logic [axf_pkg::DATA_W-1:0]  left_operand,
    input  logic [axf_pkg::DATA_W-1:0]  right_operand,
    input  logic [3:0]                  condition_code,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [axf_pkg::DATA_W-1:0]  result_value,
    output logic                        write_back,
    output logic                        branch_taken,
    output logic                        divide_fault,
    output logic [axf_pkg::FLAGS_W-1:0] flags_value
);
    import axf_pkg::*;

    // Commands from the controller and status back from the datapath.
    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // The controller accepts a beat only when idle. A finished result sits
    // in the datapath's output registers, so the next beat can be taken and
    // executed while the sink still stalls; it is committed only once the
    // output register is free.
    axf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds operands, the adder and divider, the flags register
    // and the output registers. Flags update together with the output
    // registers, so the flags seen with a result are always its own.
    axf_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .word_size      (word_size),
        .left_operand   (left_operand),
        .right_operand  (right_operand),
        .condition_code (condition_code),
        .result_value   (result_value),
        .write_back     (write_back),
        .branch_taken   (branch_taken),
        .divide_fault   (divide_fault),
        .flags_value    (flags_value)
    );

endmodule

/* sim/alu_flags_checker.sv */
// ----------------------------------------------------------------------------
// alu_flags_checker: scoreboard for the 8086-style ALU flags unit
// Watches the operand and result channels and keeps its own copy of the
// flags register. It predicts every result from the accepted operand beats
// and compares each returned beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alu_flags_checker
    import axf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [3:0]          opcode,
    input  logic                word_size,
    input  logic [DATA_W-1:0]   left_operand,
    input  logic [DATA_W-1:0]   right_operand,
    input  logic [3:0]          condition_code,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [DATA_W-1:0]   result_value,
    input  logic                write_back,
    input  logic                branch_taken,
    input  logic                divide_fault,
    input  logic [FLAGS_W-1:0]  flags_value,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic               wb;
        logic               taken;
        logic               fault;
        logic [FLAGS_W-1:0] flags;
    } alu_result_t;

    alu_result_t        awaited_results[$];
    logic [FLAGS_W-1:0] model_flags;

    // Sign, zero and parity; parity always looks at the low byte only.
    function automatic logic [7:0] szp_flags(input logic [15:0] res, input logic wsz);
        logic [7:0] f;
        f           = '0;
        f[F_PARITY] = ~^res[7:0];
        f[F_ZERO]   = (res == 16'h0000);
        f[F_SIGN]   = wsz ? res[15] : res[7];
        return f;
    endfunction

    function automatic logic [7:0] arith_flags(input logic [15:0] a, input logic [15:0] b,
                                               input logic sub, input logic wsz,
                                               output logic [15:0] res);
        logic [16:0] wide;
        logic [7:0]  f;
        logic        sa;
        logic        sb;
        logic        sr;
        wide = sub ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, b});
        res  = wsz ? wide[15:0] : {8'h00, wide[7:0]};
        f    = szp_flags(res, wsz);
        sa   = wsz ? a[15] : a[7];
        sb   = wsz ? b[15] : b[7];
        sr   = wsz ? res[15] : res[7];
        f[F_CARRY]  = sub ? (a < b) : (wsz ? wide[16] : wide[8]);
        f[F_OVFL]   = sub ? ((sr ^ sa) & (sa ^ sb)) : ((sr ^ sa) & ~(sa ^ sb));
        f[F_ADJUST] = a[4] ^ b[4] ^ res[4];
        return f;
    endfunction

    function automatic logic cond_holds(input logic [3:0] cc, input logic [7:0] fl);
        logic base;
        case (cond_grp_t'(cc[3:1]))
            CG_O:    base = fl[F_OVFL];
            CG_B:    base = fl[F_CARRY];
            CG_Z:    base = fl[F_ZERO];
            CG_BE:   base = fl[F_CARRY] | fl[F_ZERO];
            CG_S:    base = fl[F_SIGN];
            CG_P:    base = fl[F_PARITY];
            CG_L:    base = fl[F_SIGN] ^ fl[F_OVFL];
            default: base = (fl[F_SIGN] ^ fl[F_OVFL]) | fl[F_ZERO];
        endcase
        return base ^ cc[0];
    endfunction

    function automatic alu_result_t predict_alu(input logic [3:0] code, input logic wsz,
                                                input logic [15:0] lo, input logic [15:0] ro,
                                                input logic [3:0] cc, input logic [7:0] fl);
        alu_result_t r;
        logic [15:0] mask;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] res;
        logic [7:0]  keep;
        logic [7:0]  nf;
        r       = '0;
        r.flags = fl;
        mask    = wsz ? 16'hFFFF : 16'h00FF;
        a       = lo & mask;
        b       = ro & mask;
        keep    = '0;
        keep[F_INTR] = fl[F_INTR];
        keep[F_DIR]  = fl[F_DIR];
        case (code)
            OP_ADD, OP_CMP:
            begin
                nf      = arith_flags(a, b, code == OP_CMP, wsz, res);
                r.value = res;
                r.wb    = (code == OP_ADD);
                r.flags = nf | keep;
            end
            OP_INC, OP_DEC:
            begin
                nf           = arith_flags(a, 16'h0001, code == OP_DEC, wsz, res);
                nf[F_CARRY]  = fl[F_CARRY];
                r.value      = res;
                r.wb         = 1'b1;
                r.flags      = nf | keep;
            end
            OP_XOR:
            begin
                res          = a ^ b;
                nf           = szp_flags(res, wsz);
                nf[F_ADJUST] = fl[F_ADJUST];
                r.value      = res;
                r.wb         = 1'b1;
                r.flags      = nf | keep;
            end
            OP_DIV:
            begin
                if (b == 16'h0000)
                begin
                    r.fault = 1'b1;
                end
                else
                begin
                    r.value = a / b;
                    r.wb    = 1'b1;
                end
            end
            OP_COND: r.taken = cond_holds(cc, fl);
            OP_STC:  r.flags[F_CARRY] = 1'b1;
            OP_CLD:  r.flags[F_DIR]   = 1'b0;
            OP_STD:  r.flags[F_DIR]   = 1'b1;
            OP_CLI:  r.flags[F_INTR]  = 1'b0;
            OP_STI:  r.flags[F_INTR]  = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t want;
        if (!rst_n)
        begin
            model_flags = '0;
            awaited_results.delete();
            fail_count  = 0;
        end
        else
        begin
            // Results are checked before the new operand beat is queued; a result
            // can never belong to a beat accepted at the same edge.
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with nothing outstanding: value 0x%0h", result_value);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("result_value", want.value, result_value);
                    check_field("write_back", want.wb, write_back);
                    check_field("branch_taken", want.taken, branch_taken);
                    check_field("divide_fault", want.fault, divide_fault);
                    check_field("flags_value", want.flags, flags_value);
                end
            end
            if (in_valid && !in_stall)
            begin
                want = predict_alu(opcode, word_size, left_operand, right_operand,
                                   condition_code, model_flags);
                model_flags = want.flags;
                awaited_results.push_back(want);
            end
        end
        pending = awaited_results.size();
    end

endmodule

/* sim/x86_alu_flags_unit_tb.sv */
// ----------------------------------------------------------------------------
// x86_alu_flags_unit_tb: top-level testbench of the ALU flags unit
// Drives a directed set of operand beats and then random ones through four
// idling phases, while a checker beside the unit predicts and compares every
// result beat. A watchdog ends the run if the channels go quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module x86_alu_flags_unit_tb;
    import axf_pkg::*;

    localparam int         RANDOM_BEATS   = 200;   // per idling phase
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         SETTLE_CYCLES  = 40;    // longer than a divide
    // Opcodes with no defined operation; the unit must treat them as no-ops.
    localparam logic [3:0] OP_NONE_FIRST  = 4'd12;
    localparam logic [3:0] OP_NONE_LAST   = 4'd15;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [3:0]          opcode         = '0;
    logic                word_size      = 1'b0;
    logic [DATA_W-1:0]   left_operand   = '0;
    logic [DATA_W-1:0]   right_operand  = '0;
    logic [3:0]          condition_code = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [DATA_W-1:0]   result_value;
    logic                write_back;
    logic                branch_taken;
    logic                divide_fault;
    logic [FLAGS_W-1:0]  flags_value;

    int fail_count;
    int pending;
    int gap_pct     = 0;   // chance in a hundred that the sender idles a cycle
    int stall_pct   = 0;   // chance in a hundred that the receiver stalls a cycle
    int quiet_count = 0;

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    x86_alu_flags_unit u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .word_size      (word_size),
        .left_operand   (left_operand),
        .right_operand  (right_operand),
        .condition_code (condition_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_value   (result_value),
        .write_back     (write_back),
        .branch_taken   (branch_taken),
        .divide_fault   (divide_fault),
        .flags_value    (flags_value)
    );

    alu_flags_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .word_size      (word_size),
        .left_operand   (left_operand),
        .right_operand  (right_operand),
        .condition_code (condition_code),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_value   (result_value),
        .write_back     (write_back),
        .branch_taken   (branch_taken),
        .divide_fault   (divide_fault),
        .flags_value    (flags_value),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // The receiver decides its stall for the coming edge at every falling edge,
    // so stall runs are geometric and land on every phase of a divide.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: any accepted beat on either channel restarts the count. The
    // longest honest quiet stretch is a divide plus a long receiver stall, far
    // below the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_count = 0;
        end
        else
        begin
            quiet_count++;
            if (quiet_count >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Presents one operand beat and returns at the falling edge after it was
    // taken. Called at a falling edge. Valid stays high between back-to-back
    // beats and the payload holds still while the unit stalls.
    task automatic issue_beat(input logic [3:0] code, input logic wsz,
                              input logic [15:0] lo, input logic [15:0] ro,
                              input logic [3:0] cc);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
        in_valid       <= 1'b1;
        opcode         <= code;
        word_size      <= wsz;
        left_operand   <= lo;
        right_operand  <= ro;
        condition_code <= cc;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Holds the sender off until every outstanding result has been returned.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    // Operands lean on the boundaries that move carry, overflow and adjust;
    // with the byte boundaries the upper byte is random so that byte operations see junk there.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return {8'($urandom()), 8'h80};
            5:       return {8'($urandom()), 8'h7F};
            6:       return {8'($urandom()), 8'hFF};
            7:       return {8'($urandom()), 8'h0F};
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic issue_random_beat();
        logic [3:0]  code;
        logic [15:0] ro;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 58)
            code = 4'($urandom_range(int'(OP_ADD), int'(OP_XOR)));
        else if (sel < 68)
            code = OP_DIV;
        else if (sel < 84)
            code = OP_COND;
        else if (sel < 96)
            code = 4'($urandom_range(int'(OP_STC), int'(OP_STI)));
        else
            code = 4'($urandom_range(int'(OP_NONE_FIRST), int'(OP_NONE_LAST)));
        ro = pick_operand();
        // Divisors: some zero at the operand size, some small for long quotients.
        if (code == OP_DIV)
        begin
            case ($urandom_range(0, 7))
                0:       ro = {8'($urandom()), 8'h00};
                1:       ro = 16'h0000;
                2:       ro = 16'($urandom_range(1, 15));
                default: ;
            endcase
        end
        issue_beat(code, 1'($urandom()), pick_operand(), ro, 4'($urandom()));
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats, no idling on either side.
        issue_beat(OP_ADD,  1'b1, 16'hFFFF, 16'h0001, 4'h0);  // word carry out to zero
        issue_beat(OP_ADD,  1'b0, 16'hA57F, 16'h3C01, 4'h0);  // byte overflow and adjust
        issue_beat(OP_ADD,  1'b1, 16'h7FFF, 16'h7FFF, 4'h0);  // word signed overflow
        issue_beat(OP_CMP,  1'b0, 16'h1200, 16'h0001, 4'h0);  // byte borrow
        issue_beat(OP_CMP,  1'b1, 16'h8000, 16'h0001, 4'h0);  // word overflow on subtract
        issue_beat(OP_INC,  1'b0, 16'h00FF, 16'h0000, 4'h0);  // wraps to zero, carry kept
        issue_beat(OP_DEC,  1'b1, 16'h0000, 16'h0000, 4'h0);  // wraps to all ones
        issue_beat(OP_XOR,  1'b1, 16'hFFFF, 16'h00FF, 4'h0);  // word sign, byte-based parity
        issue_beat(OP_XOR,  1'b0, 16'hAB55, 16'h1255, 4'h0);  // byte zero, adjust untouched
        issue_beat(OP_COND, 1'b0, 16'h0000, 16'h0000, 4'h4);  // taken on zero
        issue_beat(OP_COND, 1'b0, 16'h0000, 16'h0000, 4'hF);  // greater than
        issue_beat(OP_DIV,  1'b1, 16'hFFFF, 16'h0001, 4'h0);
        issue_beat(OP_DIV,  1'b0, 16'hFFC8, 16'hEE07, 4'h0);  // byte divide, upper bytes junk
        issue_beat(OP_DIV,  1'b0, 16'h0010, 16'h3400, 4'h0);  // divisor zero at byte size
        issue_beat(OP_DIV,  1'b1, 16'h1234, 16'h0000, 4'h0);  // divisor zero at word size
        issue_beat(OP_STC,  1'b0, 16'h0000, 16'h0000, 4'h0);
        issue_beat(OP_STD,  1'b0, 16'h0000, 16'h0000, 4'h0);
        issue_beat(OP_STI,  1'b0, 16'h0000, 16'h0000, 4'h0);
        issue_beat(OP_COND, 1'b1, 16'hFFFF, 16'hFFFF, 4'h2);  // below, after carry set
        issue_beat(OP_ADD,  1'b0, 16'h0001, 16'h0001, 4'h0);  // control flags survive add
        issue_beat(OP_CLD,  1'b0, 16'h0000, 16'h0000, 4'h0);
        issue_beat(OP_CLI,  1'b0, 16'h0000, 16'h0000, 4'h0);
        issue_beat(OP_NONE_FIRST, 1'b1, 16'hFFFF, 16'hFFFF, 4'hF);
        issue_beat(OP_NONE_LAST,  1'b0, 16'h8000, 16'h0001, 4'h5);
        hold_until_drained();

        // Random phases: free flow, sender gaps, receiver stalls, then both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 66; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 66; end
                default: begin gap_pct = 14; stall_pct = 14; end
            endcase
            repeat (RANDOM_BEATS) issue_random_beat();
            // Let the pipeline empty completely before the next phase.
            hold_until_drained();
        end

        // Catch any stray result beat once nothing should be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
sv/axf_pkg.sv
sv/axf_ctrl.sv
sv/axf_dp.sv
sv/x86_alu_flags_unit.sv
sim/alu_flags_checker.sv
sim/x86_alu_flags_unit_tb.sv
